// ----- rtl/rspe_pkg.sv -----
// ----------------------------------------------------------------------------
// rspe_pkg
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity
// encoder.
// ----------------------------------------------------------------------------
package rspe_pkg;

    // default number of remainder stages
    localparam int MAX_PARITY_DEF = 32;
    // parity count loaded at reset
    localparam int RESET_PARITY   = 32;
    // width of the parity count register field
    localparam int CFG_W          = 6;
    // field polynomial x^8+x^4+x^3+x^2+1, low byte (x^8 term implied)
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;
    // first generator root, alpha^1
    localparam logic [7:0] ALPHA = 8'h02;

    // one message symbol request
    typedef struct packed {
        logic [7:0] data_symbol;
        logic       last_symbol;
    } sym_req_t;

    // one parity symbol request
    typedef struct packed {
        logic [7:0] parity_symbol;
        logic       parity_last;
    } par_req_t;

    // multiply by alpha
    function automatic logic [7:0] gf_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    // general GF(256) product, shift-and-add over the bits of b
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

// ----- rtl/reed_solomon_parity_encoder_top.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_top
// Systematic RS parity encoder over GF(256): parallel remainder LFSR,
// iterative generator build and a parity output shift buffer.
// ----------------------------------------------------------------------------
// Message symbols are taken one per cycle while sym_stall is low; each updates
// every remainder stage at once through one GF multiplier per stage. A symbol
// marked last loads the finished remainder into the output buffer, which sends
// the p parity symbols one per cycle while par_stall is low, index zero first,
// while the next message already streams in. A last symbol is held off while
// the previous parity burst still drains, so messages longer than p symbols
// run with no gaps. After reset and each parity count write, the generator
// polynomial is rebuilt one root per cycle while the input stalls.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_top #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sym_valid,
    output logic                        sym_stall,
    input  rspe_pkg::sym_req_t          sym_data,
    output logic                        par_valid,
    input  logic                        par_stall,
    output rspe_pkg::par_req_t          par_data,
    input  logic                        cfg_write,
    input  logic [rspe_pkg::CFG_W-1:0]  cfg_data
);

    localparam int CW      = $clog2(MAX_PARITY + 1);
    localparam int RESET_P = (rspe_pkg::RESET_PARITY < MAX_PARITY) ?
                             rspe_pkg::RESET_PARITY : MAX_PARITY;

    // parity count and generator build state
    logic [CW-1:0] parity_reg;
    logic [CW-1:0] parity_next;
    logic          gen_busy_reg;
    logic [CW-1:0] gen_step_reg;
    logic [7:0]    root_reg;
    logic [7:0]    gen_reg  [1:MAX_PARITY];
    logic [7:0]    gen_next [1:MAX_PARITY];

    // remainder and output buffer
    logic [7:0]    rem_reg  [0:MAX_PARITY-1];
    logic [7:0]    rem_next [0:MAX_PARITY-1];
    logic [7:0]    obuf_reg [0:MAX_PARITY-1];
    logic [CW-1:0] ocount_reg;
    logic [7:0]    feedback;
    logic          sym_take;
    logic          par_take;

    // handshake
    assign sym_stall = gen_busy_reg || (sym_data.last_symbol && (ocount_reg != '0));
    assign sym_take  = sym_valid && !sym_stall;
    assign par_valid = (ocount_reg != '0);
    assign par_take  = par_valid && !par_stall;

    assign par_data.parity_symbol = obuf_reg[0];
    assign par_data.parity_last   = (ocount_reg == CW'(1));

    // clamp of written parity count
    always_comb
    begin
        if (cfg_data == '0)
        begin
            parity_next = CW'(1);
        end
        else if (32'(cfg_data) > MAX_PARITY)
        begin
            parity_next = CW'(MAX_PARITY);
        end
        else
        begin
            parity_next = CW'(cfg_data);
        end
    end

    // one generator step: multiply by (x + root)
    always_comb
    begin
        gen_next[1] = gen_reg[1] ^ root_reg;
        for (int j = 2; j <= MAX_PARITY; j++)
        begin
            gen_next[j] = gen_reg[j] ^ rspe_pkg::gf_mul(root_reg, gen_reg[j-1]);
        end
    end

    // remainder update, all stages in parallel
    assign feedback = sym_data.data_symbol ^ rem_reg[0];

    always_comb
    begin
        for (int j = 0; j < MAX_PARITY - 1; j++)
        begin
            rem_next[j] = rem_reg[j+1] ^ rspe_pkg::gf_mul(feedback, gen_reg[j+1]);
        end
        rem_next[MAX_PARITY-1] = rspe_pkg::gf_mul(feedback, gen_reg[MAX_PARITY]);
    end

    // parity count and generator build
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg   <= CW'(RESET_P);
            gen_busy_reg <= 1'b1;
            gen_step_reg <= '0;
            root_reg     <= rspe_pkg::ALPHA;
            for (int j = 1; j <= MAX_PARITY; j++)
            begin
                gen_reg[j] <= 8'h00;
            end
        end
        else if (cfg_write)
        begin
            parity_reg   <= parity_next;
            gen_busy_reg <= 1'b1;
            gen_step_reg <= '0;
            root_reg     <= rspe_pkg::ALPHA;
            for (int j = 1; j <= MAX_PARITY; j++)
            begin
                gen_reg[j] <= 8'h00;
            end
        end
        else if (gen_busy_reg)
        begin
            gen_reg      <= gen_next;
            root_reg     <= rspe_pkg::gf_xtime(root_reg);
            gen_step_reg <= gen_step_reg + CW'(1);
            if (gen_step_reg == parity_reg - CW'(1))
            begin
                gen_busy_reg <= 1'b0;
            end
        end
    end

    // remainder shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                rem_reg[j] <= 8'h00;
            end
        end
        else if (cfg_write || (sym_take && sym_data.last_symbol))
        begin
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                rem_reg[j] <= 8'h00;
            end
        end
        else if (sym_take)
        begin
            rem_reg <= rem_next;
        end
    end

    // output buffer fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocount_reg <= '0;
        end
        else if (sym_take && sym_data.last_symbol)
        begin
            ocount_reg <= parity_reg;
        end
        else if (par_take)
        begin
            ocount_reg <= ocount_reg - CW'(1);
        end
    end

    // output buffer data, loaded on a last symbol and shifted per request
    always_ff @(posedge clk)
    begin
        if (sym_take && sym_data.last_symbol)
        begin
            obuf_reg <= rem_next;
        end
        else if (par_take)
        begin
            for (int j = 0; j < MAX_PARITY - 1; j++)
            begin
                obuf_reg[j] <= obuf_reg[j+1];
            end
            obuf_reg[MAX_PARITY-1] <= 8'h00;
        end
    end

endmodule

// ----- rtl/rspe_checker.sv -----
// ----------------------------------------------------------------------------
// rspe_checker
// Port-level checks for the Reed-Solomon parity encoder, bound to the top.
// ----------------------------------------------------------------------------
module rspe_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    input  logic               sym_stall,
    input  rspe_pkg::sym_req_t sym_data,
    input  logic               par_valid,
    input  logic               par_stall,
    input  rspe_pkg::par_req_t par_data,
    input  logic               cfg_write
);

    // a stalled parity request stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        par_valid && par_stall |=> par_valid)
    else $error("parity request dropped while stalled");

    // generator rebuild holds off message symbols
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> sym_stall)
    else $error("symbol accepted during generator rebuild");

    // a last message symbol starts a parity burst
    assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_stall && sym_data.last_symbol |=> par_valid)
    else $error("no parity after last symbol");

    // burst ends after its last parity symbol
    assert property (@(posedge clk) disable iff (!rst_n)
        par_valid && !par_stall && par_data.parity_last |=> !par_valid)
    else $error("parity continues past last flag");

    // a new codeword waits for the previous burst
    assert property (@(posedge clk) disable iff (!rst_n)
        par_valid && sym_valid && sym_data.last_symbol |-> sym_stall)
    else $error("last symbol accepted while parity burst pending");

endmodule

bind reed_solomon_parity_encoder_top rspe_checker u_rspe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_data  (sym_data),
    .par_valid (par_valid),
    .par_stall (par_stall),
    .par_data  (par_data),
    .cfg_write (cfg_write)
);
